### rtl/core/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, codes and constants for the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int PIN_W          = 7;
    localparam int IDX_W          = 3;
    localparam int OP_W           = 2;
    localparam int CFG_W          = 10;
    localparam int COUNT_W        = 8;
    localparam int S_DATA_W       = 16;
    localparam int S_USER_W       = 2;
    localparam int M_DATA_W       = 16;
    localparam int BUTTON_COUNT_DEF = 7;
    localparam int HOLD_WIDTH_DEF   = 10;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 10'd50;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_READ_EDGE  = 2'd1,
        OP_READ_COUNT = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef struct packed {
        logic tick;
        logic raw_pressed;
        logic clr_edge;
        logic clr_count;
    } lane_ctrl_t;

    typedef struct packed {
        logic               stable_next;
        logic               edge_flag;
        logic [COUNT_W-1:0] count;
    } lane_stat_t;

endpackage

### rtl/core/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane
// Debouncer for one button: candidate level, saturating hold counter,
// stable level, sticky press flag and wrapping press counter.
// ----------------------------------------------------------------------------
module mbd_lane #(
    parameter int HOLD_WIDTH = mbd_pkg::HOLD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbd_pkg::lane_ctrl_t         ctrl,
    input  logic [mbd_pkg::CFG_W-1:0]   debounce_ms,
    output mbd_pkg::lane_stat_t         stat
);
    import mbd_pkg::*;

    localparam int CMP_W = (HOLD_WIDTH > CFG_W) ? HOLD_WIDTH : CFG_W;

    logic                  cand_reg, cand_next;
    logic                  stable_reg, stable_next;
    logic                  edge_reg, edge_next;
    logic [HOLD_WIDTH-1:0] hold_reg, hold_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [HOLD_WIDTH-1:0] hold_eff;
    logic                  held_long;

    always_comb
    begin
        cand_next   = cand_reg;
        stable_next = stable_reg;
        edge_next   = edge_reg;
        hold_next   = hold_reg;
        count_next  = count_reg;
        hold_eff    = hold_reg;
        held_long   = 1'b0;
        if (ctrl.tick)
        begin
            if (ctrl.raw_pressed != cand_reg)
            begin
                hold_eff  = '0;
                cand_next = ctrl.raw_pressed;
            end
            held_long = CMP_W'(hold_eff) > CMP_W'(debounce_ms);
            if (held_long)
            begin
                if (ctrl.raw_pressed && !stable_reg)
                begin
                    stable_next = 1'b1;
                    edge_next   = 1'b1;
                    count_next  = count_reg + 8'd1;
                end
                else if (!ctrl.raw_pressed && stable_reg)
                begin
                    stable_next = 1'b0;
                end
            end
            hold_next = (&hold_eff) ? hold_eff : hold_eff + HOLD_WIDTH'(1);
        end
        if (ctrl.clr_edge)
        begin
            edge_next = 1'b0;
        end
        if (ctrl.clr_count)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg   <= 1'b0;
            stable_reg <= 1'b0;
            edge_reg   <= 1'b0;
            hold_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cand_reg   <= cand_next;
            stable_reg <= stable_next;
            edge_reg   <= edge_next;
            hold_reg   <= hold_next;
            count_reg  <= count_next;
        end
    end

    assign stat.stable_next = stable_next;
    assign stat.edge_flag   = edge_reg;
    assign stat.count       = count_reg;

endmodule

### rtl/core/mbd_merge.sv
// ----------------------------------------------------------------------------
// mbd_merge
// Gathers the lane results into one item and holds it in the output
// register until the sink takes it.
// ----------------------------------------------------------------------------
module mbd_merge #(
    parameter int BUTTON_COUNT = mbd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  mbd_pkg::op_t                        op,
    input  logic [mbd_pkg::IDX_W-1:0]           button_index,
    input  mbd_pkg::lane_stat_t [BUTTON_COUNT-1:0] stats,
    output logic                                in_ready,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mbd_pkg::M_DATA_W-1:0]        m_axis_tdata
);
    import mbd_pkg::*;

    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg;
    logic [PIN_W-1:0]    mask;
    logic                sel_edge;
    logic [COUNT_W-1:0]  sel_count;
    logic                edge_out;
    logic [COUNT_W-1:0]  count_out;

    always_comb
    begin
        mask      = '0;
        sel_edge  = 1'b0;
        sel_count = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            mask[i] = stats[i].stable_next;
            if (button_index == IDX_W'(i))
            begin
                sel_edge  = stats[i].edge_flag;
                sel_count = stats[i].count;
            end
        end
        edge_out  = 1'b0;
        count_out = '0;
        case (op)
            OP_READ_EDGE:  edge_out  = sel_edge;
            OP_READ_COUNT: count_out = sel_count;
            default:
            begin
                edge_out  = 1'b0;
                count_out = '0;
            end
        endcase
    end

    assign in_ready   = !valid_reg || m_axis_tready;
    assign valid_next = accept ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= {count_out, edge_out, mask};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

### rtl/core/multi_button_debouncer.sv
// ----------------------------------------------------------------------------
// multi_button_debouncer
// Debounces up to seven active-low buttons, one lane per button, with
// sticky press flags and press counters that read and clear per button.
//
// channel   direction  fields (low bit first)
// s_axis    in         tdata: pin_levels[6:0] button_index[9:7]; tuser: op[1:0]
// m_axis    out        tdata: stable_mask[6:0] edge_seen[7] press_total[15:8]
// cfg       in         cfg_wdata: debounce_ms[9:0], written when cfg_we is high
//
// one item per cycle while s_axis_tready is high; the lanes update in the
// accept cycle and the result sits in the output register from the next cycle on
// s_axis_tready drops only while a result is held and m_axis_tready is low
// reset clears all lanes, the output valid flag and sets debounce_ms to 50
// ----------------------------------------------------------------------------
module multi_button_debouncer #(
    parameter int BUTTON_COUNT = mbd_pkg::BUTTON_COUNT_DEF,
    parameter int HOLD_WIDTH   = mbd_pkg::HOLD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mbd_pkg::S_DATA_W-1:0]  s_axis_tdata,  // pin_levels, button_index
    input  logic [mbd_pkg::S_USER_W-1:0]  s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mbd_pkg::M_DATA_W-1:0]  m_axis_tdata,  // stable_mask, edge_seen, press_total
    input  logic                          cfg_we,
    input  logic [mbd_pkg::CFG_W-1:0]     cfg_wdata
);
    import mbd_pkg::*;

    logic                   accept;
    logic                   in_ready;
    op_t                    op;
    logic [PIN_W-1:0]       pin_levels;
    logic [IDX_W-1:0]       button_index;
    logic [CFG_W-1:0]       debounce_reg;
    lane_ctrl_t [BUTTON_COUNT-1:0] ctrl;
    lane_stat_t [BUTTON_COUNT-1:0] stats;

    assign op           = op_t'(s_axis_tuser);
    assign pin_levels   = s_axis_tdata[PIN_W-1:0];
    assign button_index = s_axis_tdata[PIN_W+IDX_W-1:PIN_W];
    assign accept       = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_lane
        assign ctrl[i].tick        = accept && (op == OP_TICK);
        assign ctrl[i].raw_pressed = !pin_levels[i];
        assign ctrl[i].clr_edge    = accept && (op == OP_READ_EDGE)
                                     && (button_index == IDX_W'(i));
        assign ctrl[i].clr_count   = accept && (op == OP_READ_COUNT)
                                     && (button_index == IDX_W'(i));

        mbd_lane #(
            .HOLD_WIDTH (HOLD_WIDTH)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl[i]),
            .debounce_ms (debounce_reg),
            .stat        (stats[i])
        );
    end

    mbd_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op),
        .button_index  (button_index),
        .stats         (stats),
        .in_ready      (in_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### rtl/core/mbd_checker.sv
// ----------------------------------------------------------------------------
// mbd_checker
// Port-level checks for the multi-button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module mbd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mbd_pkg::S_USER_W-1:0]  s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mbd_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import mbd_pkg::*;

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // input only blocked by a stalled full output register
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output stall");

    // tick result carries no flag and no count
    a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (s_axis_tuser == OP_TICK)
        |=> m_axis_tvalid && !m_axis_tdata[7] && (m_axis_tdata[15:8] == 8'd0))
        else $error("tick result with flag or count");

    // edge read carries no count
    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (s_axis_tuser == OP_READ_EDGE)
        |=> m_axis_tvalid && (m_axis_tdata[15:8] == 8'd0))
        else $error("edge read with count");

    // count read carries no flag
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && (s_axis_tuser == OP_READ_COUNT)
        |=> m_axis_tvalid && !m_axis_tdata[7])
        else $error("count read with flag");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
